FILE: src/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// Types, token codes, keyword table and character class helpers for the
// c token classifier.
// ----------------------------------------------------------------------------
package ctc_pkg;

  localparam int unsigned MAX_TOKEN_LEN = 255;
  localparam int unsigned LEN_W         = 8;
  localparam int unsigned LEN_SAT_INT   = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
  localparam logic [LEN_W-1:0] LEN_SAT  = LEN_SAT_INT[LEN_W-1:0];
  localparam int unsigned KW_COUNT      = 12;
  localparam int unsigned KW_MAX_LEN    = 6;
  localparam int unsigned WIN_W         = 8 * KW_MAX_LEN;

  localparam logic [2:0] CLS_PUNCT = 3'd0;
  localparam logic [2:0] CLS_OPER  = 3'd1;
  localparam logic [2:0] CLS_KWORD = 3'd2;
  localparam logic [2:0] CLS_IDENT = 3'd3;
  localparam logic [2:0] CLS_CONST = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic [2:0]       token_class;
    logic [LEN_W-1:0] token_length;
    logic [7:0]       symbol;
    logic [3:0]       keyword_index;
    logic [31:0]      start_offset;
    logic             last_result;
  } token_t;

  localparam logic [WIN_W-1:0] KW_TABLE [KW_COUNT] = '{
    48'h0000_0069_6E74,  // int
    48'h0066_6C6F_6174,  // float
    48'h0000_6368_6172,  // char
    48'h646F_7562_6C65,  // double
    48'h0000_0000_6966,  // if
    48'h0000_656C_7365,  // else
    48'h0000_0066_6F72,  // for
    48'h0077_6869_6C65,  // while
    48'h7265_7475_726E,  // return
    48'h0000_766F_6964,  // void
    48'h0000_636F_7574,  // cout
    48'h0000_0063_696E   // cin
  };

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h7D ||
           c == 8'h3B || c == 8'h2C || c == 8'h5B || c == 8'h5D;
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F ||
           c == 8'h3D || c == 8'h3C || c == 8'h3E || c == 8'h21;
  endfunction

endpackage

FILE: src/c_token_classifier.sv
// ----------------------------------------------------------------------------
// c_token_classifier
// Byte-serial lexer: classifies punctuation, operators, keywords,
// identifiers and decimal constants, with length and start offset.
// Results are registered into a four-entry queue whose head drives out_.
// Throughput: one byte per cycle while the queue has room for two words;
// a byte giving two tokens writes both, read out in order one per pop.
// Reset: synchronous, clears scanner state, byte offset and the queue.
// ----------------------------------------------------------------------------
module c_token_classifier
  import ctc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_char_code,
  input  logic             in_stream_end,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_token_class,
  output logic [LEN_W-1:0] out_token_length,
  output logic [7:0]       out_symbol,
  output logic [3:0]       out_keyword_index,
  output logic [31:0]      out_start_offset,
  output logic             out_last_result
);

  scan_mode_t       mode_r, mode_nxt;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic [31:0]      pstart_r, pstart_nxt;
  logic [31:0]      offset_r;

  token_t           fifo_r [4];
  logic [1:0]       wr_ptr_r, rd_ptr_r;
  logic [2:0]       cnt_r, cnt_nxt;

  logic             accept, pop;
  logic             ext, v_a, v_b, v_c;
  logic             c_letter, c_digit, c_punct, c_oper;
  scan_mode_t       mode_a;
  logic [WIN_W-1:0] win_a;
  logic [LEN_W-1:0] plen_a;
  logic [31:0]      pstart_a;
  token_t           res_a, res_b, res_c, first, second;
  logic [1:0]       n_res;

  function automatic token_t flush_token(input scan_mode_t m, input logic [WIN_W-1:0] w,
                                         input logic [LEN_W-1:0] l, input logic [31:0] s);
    token_t t;
    logic   hit;
    t = '0;
    hit = 1'b0;
    t.token_length = l;
    t.start_offset = s;
    if (m == MODE_WORD) begin
      t.token_class = CLS_IDENT;
      if (l <= LEN_W'(KW_MAX_LEN)) begin
        for (int i = 0; i < KW_COUNT; i++) begin
          if (!hit && w == KW_TABLE[i]) begin
            hit = 1'b1;
            t.token_class = CLS_KWORD;
            t.keyword_index = 4'(i);
          end
        end
      end
    end else begin
      t.token_class = CLS_CONST;
    end
    return t;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && out_ready;

  assign c_letter = is_letter(in_char_code);
  assign c_digit  = is_digit(in_char_code);
  assign c_punct  = is_punct(in_char_code);
  assign c_oper   = is_oper(in_char_code);

  always_comb begin
    ext = ((mode_r == MODE_WORD) && (c_letter || c_digit)) ||
          ((mode_r == MODE_NUM) && c_digit);
    v_a = (mode_r != MODE_IDLE) && !ext;
    v_b = !ext && (c_punct || c_oper);

    res_a = flush_token(mode_r, win_r, plen_r, pstart_r);

    res_b = '0;
    res_b.token_class  = c_punct ? CLS_PUNCT : CLS_OPER;
    res_b.token_length = LEN_W'(1);
    res_b.symbol       = in_char_code;
    res_b.start_offset = offset_r;

    // state after the byte, before any end-of-stream flush
    mode_a   = mode_r;
    win_a    = win_r;
    plen_a   = plen_r;
    pstart_a = pstart_r;
    if (ext) begin
      if (plen_r < LEN_SAT) begin
        plen_a = plen_r + LEN_W'(1);
      end
      if (mode_r == MODE_WORD) begin
        win_a = {win_r[WIN_W-9:0], in_char_code};
      end
    end else begin
      mode_a = MODE_IDLE;
      win_a  = '0;
      plen_a = '0;
      if (!c_punct && !c_oper && (c_letter || c_digit)) begin
        mode_a   = c_letter ? MODE_WORD : MODE_NUM;
        plen_a   = LEN_W'(1);
        pstart_a = offset_r;
        win_a    = c_letter ? WIN_W'(in_char_code) : '0;
      end
    end

    v_c   = in_stream_end && (mode_a != MODE_IDLE);
    res_c = flush_token(mode_a, win_a, plen_a, pstart_a);

    mode_nxt   = mode_a;
    win_nxt    = win_a;
    plen_nxt   = plen_a;
    pstart_nxt = pstart_a;
    if (in_stream_end) begin
      mode_nxt = MODE_IDLE;
      win_nxt  = '0;
      plen_nxt = '0;
    end

    // compact the up to two valid results
    first  = v_a ? res_a : (v_b ? res_b : res_c);
    second = (v_a && v_b) ? res_b : res_c;
    n_res  = 2'(v_a) + 2'(v_b) + 2'(v_c);
    first.last_result  = (n_res == 2'd1);
    second.last_result = 1'b1;

    cnt_nxt = cnt_r - 3'(pop);
    if (accept) begin
      cnt_nxt = cnt_nxt + 3'(n_res);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      win_r    <= '0;
      plen_r   <= '0;
      pstart_r <= '0;
      offset_r <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (accept) begin
        mode_r   <= mode_nxt;
        win_r    <= win_nxt;
        plen_r   <= plen_nxt;
        pstart_r <= pstart_nxt;
        offset_r <= offset_r + 32'd1;
        wr_ptr_r <= wr_ptr_r + n_res;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      fifo_r[wr_ptr_r] <= first;
    end
    if (accept && n_res == 2'd2) begin
      fifo_r[wr_ptr_r + 2'd1] <= second;
    end
  end

  assign out_token_class   = fifo_r[rd_ptr_r].token_class;
  assign out_token_length  = fifo_r[rd_ptr_r].token_length;
  assign out_symbol        = fifo_r[rd_ptr_r].symbol;
  assign out_keyword_index = fifo_r[rd_ptr_r].keyword_index;
  assign out_start_offset  = fifo_r[rd_ptr_r].start_offset;
  assign out_last_result   = fifo_r[rd_ptr_r].last_result;

endmodule
